// ----- sv/binary_max_heap_queue_assert.svh -----
// Assertion macros used by the heap queue top level.
// Define NO_ASSERTIONS to compile them out.
`ifndef BINARY_MAX_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MAX_HEAP_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define BHQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("heap queue check failed");

// Consequent must hold in the cycle after the antecedent.
`define BHQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("heap queue check failed");

`else

`define BHQ_ASSERT_SAME(label, clk, rst, ante, cons)
`define BHQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- sv/bhq_pkg.sv -----
package bhq_pkg;

   // Default sizes of the queue.
   localparam int unsigned CAPACITY_DEF  = 1024;
   localparam int unsigned KEY_WIDTH_DEF = 32;

   // Fixed field widths.
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned PRIO_W   = 32;
   localparam int unsigned FILL_W   = 11;
   localparam int unsigned STATUS_W = 2;

   // Command codes.
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // One result item.
   typedef struct packed {
      logic [DATA_W-1:0] out_key;
      logic [PRIO_W-1:0] out_priority;
      status_type        status;
      logic [FILL_W-1:0] fill_level;
   } rsp_type;

endpackage

// ----- sv/bhq_store.sv -----
module bhq_store #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned WIDTH = 64,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Two registered read ports.
   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ----- sv/bhq_engine.sv -----
module bhq_engine #(
   parameter int unsigned CAPACITY  = bhq_pkg::CAPACITY_DEF,
   parameter int unsigned KEY_WIDTH = bhq_pkg::KEY_WIDTH_DEF,
   localparam int unsigned SKW = (KEY_WIDTH < bhq_pkg::DATA_W) ? KEY_WIDTH : bhq_pkg::DATA_W,
   localparam int unsigned EW  = SKW + bhq_pkg::PRIO_W,
   localparam int unsigned IW  = $clog2(CAPACITY)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_command,
   input  logic [bhq_pkg::DATA_W-1:0]  req_key,
   input  logic [bhq_pkg::PRIO_W-1:0]  req_priority,
   output logic                        res_valid,
   input  logic                        res_ready,
   output bhq_pkg::rsp_type            res,
   output logic                        mem_wr_en,
   output logic [IW-1:0]               mem_wr_addr,
   output logic [EW-1:0]               mem_wr_data,
   output logic [IW-1:0]               mem_rd_addr_a,
   output logic [IW-1:0]               mem_rd_addr_b,
   input  logic [EW-1:0]               mem_rd_data_a,
   input  logic [EW-1:0]               mem_rd_data_b
);

   import bhq_pkg::*;

   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned XW = IW + 2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP_READ,
      S_UP,
      S_DOWN,
      S_RESULT
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [IW-1:0]     pos_ff, pos_in;
   logic [EW-1:0]     elem_ff, elem_in;
   rsp_type           res_ff, res_in;

   logic [IW-1:0]     parent_idx;
   logic [XW-1:0]     left_idx, right_idx, count_x;
   logic              left_ok, right_ok, take_left, take_right;
   logic [PRIO_W-1:0] elem_prio, left_prio, right_prio, best_prio;
   logic [IW-1:0]     child_idx;
   logic [XW-1:0]     child_left, child_right;
   logic [31:0]       count_wide;

   // Neighbors of the current hole position.
   always_comb begin
      parent_idx  = IW'((pos_ff - IW'(1)) >> 1);
      left_idx    = (XW'(pos_ff) << 1) + XW'(1);
      right_idx   = (XW'(pos_ff) << 1) + XW'(2);
      count_x     = XW'(count_ff);
      left_ok     = left_idx < count_x;
      right_ok    = right_idx < count_x;
      elem_prio   = elem_ff[PRIO_W-1:0];
      left_prio   = mem_rd_data_a[PRIO_W-1:0];
      right_prio  = mem_rd_data_b[PRIO_W-1:0];
      take_left   = left_ok && (left_prio > elem_prio);
      best_prio   = take_left ? left_prio : elem_prio;
      take_right  = right_ok && (right_prio > best_prio);
      child_idx   = take_right ? right_idx[IW-1:0] : left_idx[IW-1:0];
      child_left  = (XW'(child_idx) << 1) + XW'(1);
      child_right = (XW'(child_idx) << 1) + XW'(2);
      count_wide  = 32'(count_ff);
   end

   // Sift sequencer: one heap level per cycle against the registered reads.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      elem_in       = elem_ff;
      res_in        = res_ff;
      req_ready     = 1'b0;
      res_valid     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = pos_ff;
      mem_wr_data   = elem_ff;
      mem_rd_addr_a = '0;
      mem_rd_addr_b = '0;

      case (state_ff)
         S_IDLE: begin
            req_ready           = 1'b1;
            res_in.out_key      = '0;
            res_in.out_priority = '0;
            res_in.status       = ST_OK;
            if (req_valid) begin
               if (req_command == CMD_PUSH) begin
                  elem_in = {req_key[SKW-1:0], req_priority};
                  if (count_ff == CW'(CAPACITY)) begin
                     res_in.status = ST_FULL;
                     state_in      = S_RESULT;
                  end else if (count_ff == '0) begin
                     // First entry goes straight to the root.
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = '0;
                     mem_wr_data = {req_key[SKW-1:0], req_priority};
                     count_in    = count_ff + CW'(1);
                     state_in    = S_RESULT;
                  end else begin
                     pos_in        = count_ff[IW-1:0];
                     mem_rd_addr_a = IW'((count_ff[IW-1:0] - IW'(1)) >> 1);
                     count_in      = count_ff + CW'(1);
                     state_in      = S_UP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_in.status = ST_EMPTY;
                     state_in      = S_RESULT;
                  end else begin
                     // Fetch the root and the last entry together.
                     mem_rd_addr_a = '0;
                     mem_rd_addr_b = IW'(count_ff - CW'(1));
                     count_in      = count_ff - CW'(1);
                     state_in      = S_POP_READ;
                  end
               end
            end
         end

         S_POP_READ: begin
            res_in.out_key      = DATA_W'(mem_rd_data_a[EW-1:PRIO_W]);
            res_in.out_priority = mem_rd_data_a[PRIO_W-1:0];
            elem_in             = mem_rd_data_b;
            pos_in              = '0;
            mem_rd_addr_a       = IW'(1);
            mem_rd_addr_b       = IW'(2);
            if (count_ff == '0) begin
               state_in = S_RESULT;
            end else begin
               state_in = S_DOWN;
            end
         end

         S_UP: begin
            mem_wr_en = 1'b1;
            if (pos_ff == '0) begin
               state_in = S_RESULT;
            end else if (mem_rd_data_a[PRIO_W-1:0] < elem_prio) begin
               // Parent moves down into the hole; the next parent is fetched.
               mem_wr_data   = mem_rd_data_a;
               pos_in        = parent_idx;
               mem_rd_addr_a = IW'((parent_idx - IW'(1)) >> 1);
            end else begin
               state_in = S_RESULT;
            end
         end

         S_DOWN: begin
            mem_wr_en = 1'b1;
            if (take_left || take_right) begin
               // Larger child moves up; its children are fetched.
               mem_wr_data   = take_right ? mem_rd_data_b : mem_rd_data_a;
               pos_in        = child_idx;
               mem_rd_addr_a = child_left[IW-1:0];
               mem_rd_addr_b = child_right[IW-1:0];
            end else begin
               state_in = S_RESULT;
            end
         end

         S_RESULT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result carries the fill level after the operation.
   always_comb begin
      res            = res_ff;
      res.fill_level = count_wide[FILL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      pos_ff  <= pos_in;
      elem_ff <= elem_in;
      res_ff  <= res_in;
   end

endmodule

// ----- sv/binary_max_heap_queue.sv -----
// Binary max-heap priority queue held in one synchronous store (one write, two reads).
// A push sifts up in S_UP and a pop reads in S_POP_READ and sifts down in S_DOWN as needed;
// S_RESULT then hands the result to the output register. Refusals go straight to S_RESULT.
// Throughput: one item at a time, one heap level per cycle, set by the sift loop
// around the store's registered read.
// Reset is synchronous and empties the queue; the store itself is not cleared.
`include "binary_max_heap_queue_assert.svh"

module binary_max_heap_queue #(
   parameter int unsigned CAPACITY  = bhq_pkg::CAPACITY_DEF,
   parameter int unsigned KEY_WIDTH = bhq_pkg::KEY_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // item_key [31:0], item_priority [63:32]
   input  logic        req_tuser,   // command [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // out_key [31:0], out_priority [63:32],
                                    // fill_level [74:64], zero [79:75]
   output logic [1:0]  rsp_tuser    // status [1:0]
);

   import bhq_pkg::*;

   localparam int unsigned SKW = (KEY_WIDTH < DATA_W) ? KEY_WIDTH : DATA_W;
   localparam int unsigned EW  = SKW + PRIO_W;
   localparam int unsigned IW  = $clog2(CAPACITY);

   logic          res_valid, slot_free;
   rsp_type       res;
   logic          mem_wr_en;
   logic [IW-1:0] mem_wr_addr, mem_rd_addr_a, mem_rd_addr_b;
   logic [EW-1:0] mem_wr_data, mem_rd_data_a, mem_rd_data_b;

   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [79:0]   rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]    rsp_tuser_ff, rsp_tuser_in;

   bhq_store #(
      .DEPTH (CAPACITY),
      .WIDTH (EW)
   ) u_store (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_data   (mem_wr_data),
      .rd_addr_a (mem_rd_addr_a),
      .rd_addr_b (mem_rd_addr_b),
      .rd_data_a (mem_rd_data_a),
      .rd_data_b (mem_rd_data_b)
   );

   bhq_engine #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_command   (req_tuser),
      .req_key       (req_tdata[31:0]),
      .req_priority  (req_tdata[63:32]),
      .res_valid     (res_valid),
      .res_ready     (slot_free),
      .res           (res),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_addr_a (mem_rd_addr_a),
      .mem_rd_addr_b (mem_rd_addr_b),
      .mem_rd_data_a (mem_rd_data_a),
      .mem_rd_data_b (mem_rd_data_b)
   );

   // Output register: loads a finished result whenever the slot is empty or draining.
   always_comb begin
      slot_free     = !rsp_tvalid_ff || rsp_tready;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      if (res_valid && slot_free) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {5'b0, res.fill_level, res.out_priority, res.out_key};
         rsp_tuser_in  = res.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // The sequencer never takes a new item while it offers a result.
   `BHQ_ASSERT_SAME(a_busy_excl, clock, reset, req_tready, !res_valid)
   // A result that finds the slot occupied is held until the slot frees.
   `BHQ_ASSERT_NEXT(a_res_hold, clock, reset, res_valid && !slot_free, res_valid)
   // A refused operation carries no pair.
   `BHQ_ASSERT_SAME(a_refused_zero, clock, reset, rsp_tvalid && (rsp_tuser != ST_OK), rsp_tdata[63:0] == 64'd0)
   // An empty refusal reports an empty queue.
   `BHQ_ASSERT_SAME(a_empty_fill, clock, reset, rsp_tvalid && (rsp_tuser == ST_EMPTY), rsp_tdata[74:64] == 11'd0)

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import bhq_pkg::*;

   localparam int unsigned HEAP_SLOTS   = CAPACITY_DEF;
   localparam int unsigned MIXED_CMDS   = 450;
   localparam int unsigned BURST_PUSHES = 100;
   localparam int unsigned HOLD_CYCLES  = 400;

   // One queued command for the driver.
   typedef struct {
      logic              cmd;
      logic [DATA_W-1:0] key;
      logic [PRIO_W-1:0] prio;
      bit                drain_first;
   } heap_cmd_t;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // item_key [31:0], item_priority [63:32]
   logic        req_tuser = CMD_PUSH;   // command [0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;   // out_key [31:0], out_priority [63:32],
                             // fill_level [74:64], zero [79:75]
   logic [1:0]  rsp_tuser;   // status [1:0]

   // Shadow copy of the heap used to predict each result.
   logic [DATA_W-1:0] shadow_keys [HEAP_SLOTS];
   logic [PRIO_W-1:0] shadow_prios [HEAP_SLOTS];
   int unsigned       shadow_count = 0;

   heap_cmd_t   cmd_backlog [$];
   rsp_type     pending_results [$];
   int unsigned sent_count = 0;
   int unsigned total_cmds = 1;
   int unsigned planned_fill = 0;
   int unsigned mismatch_count = 0;
   int unsigned hold_left = 0;
   int unsigned hold_mark = 0;

   binary_max_heap_queue u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Exchange two heap slots in the shadow copy.
   function automatic void shadow_swap(int unsigned a, int unsigned b);
      logic [DATA_W-1:0] k;
      logic [PRIO_W-1:0] p;
      k = shadow_keys[a];
      p = shadow_prios[a];
      shadow_keys[a] = shadow_keys[b];
      shadow_prios[a] = shadow_prios[b];
      shadow_keys[b] = k;
      shadow_prios[b] = p;
   endfunction

   // Apply one command to the shadow heap and return the result it must produce.
   function automatic rsp_type heap_op_result(heap_cmd_t c);
      rsp_type     r;
      int unsigned pos;
      int unsigned parent;
      int unsigned lchild;
      int unsigned rchild;
      int unsigned best;
      r = '0;
      r.status = ST_OK;
      if (c.cmd == CMD_PUSH) begin
         if (shadow_count >= HEAP_SLOTS) begin
            r.status = ST_FULL;
         end else begin
            pos = shadow_count;
            shadow_keys[pos] = c.key;
            shadow_prios[pos] = c.prio;
            shadow_count++;
            // Sift up while the parent has a strictly smaller priority.
            while (pos > 0) begin
               parent = (pos - 1) / 2;
               if (shadow_prios[parent] < shadow_prios[pos]) begin
                  shadow_swap(parent, pos);
                  pos = parent;
               end else begin
                  break;
               end
            end
         end
      end else begin
         if (shadow_count == 0) begin
            r.status = ST_EMPTY;
         end else begin
            r.out_key = shadow_keys[0];
            r.out_priority = shadow_prios[0];
            shadow_count--;
            if (shadow_count > 0) begin
               shadow_keys[0] = shadow_keys[shadow_count];
               shadow_prios[0] = shadow_prios[shadow_count];
               // Sift down; the left child wins a tie between the children.
               pos = 0;
               while (pos < shadow_count) begin
                  lchild = 2 * pos + 1;
                  rchild = 2 * pos + 2;
                  best = pos;
                  if (lchild < shadow_count && shadow_prios[lchild] > shadow_prios[best])
                     best = lchild;
                  if (rchild < shadow_count && shadow_prios[rchild] > shadow_prios[best])
                     best = rchild;
                  if (best == pos)
                     break;
                  shadow_swap(pos, best);
                  pos = best;
               end
            end
         end
      end
      r.fill_level = shadow_count[FILL_W-1:0];
      return r;
   endfunction

   // Queue one command and keep a running estimate of the fill level.
   task automatic add_cmd(logic cmd, logic [DATA_W-1:0] key, logic [PRIO_W-1:0] prio,
                          bit drain_first);
      heap_cmd_t c;
      c.cmd = cmd;
      c.key = key;
      c.prio = prio;
      c.drain_first = drain_first;
      cmd_backlog.push_back(c);
      if (cmd == CMD_PUSH && planned_fill < HEAP_SLOTS)
         planned_fill++;
      else if (cmd == CMD_POP && planned_fill > 0)
         planned_fill--;
   endtask

   // Priorities: mostly random, often from a narrow range to force ties.
   function automatic logic [PRIO_W-1:0] pick_priority();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return $urandom_range(15);
         default: return $urandom;
      endcase
   endfunction

   // Traffic phase from the share of commands already sent.
   function automatic int unsigned traffic_phase();
      return (sent_count * 3) / total_cmds;
   endfunction

   function automatic int unsigned sender_idle_pct();
      case (traffic_phase())
         0:       return 19;
         1:       return 54;
         default: return 0;
      endcase
   endfunction

   function automatic int unsigned receiver_idle_pct();
      case (traffic_phase())
         0:       return 54;
         1:       return 19;
         default: return 0;
      endcase
   endfunction

   // Driver: offers queued commands and updates the prediction on each transfer.
   always @(posedge clock) begin : driver_proc
      heap_cmd_t cur;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= CMD_PUSH;
      end else begin
         if (req_tvalid && req_tready) begin
            cur.cmd = req_tuser;
            cur.key = req_tdata[31:0];
            cur.prio = req_tdata[63:32];
            cur.drain_first = 1'b0;
            pending_results.push_back(heap_op_result(cur));
            sent_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (cmd_backlog.size() != 0
                && !(cmd_backlog[0].drain_first && pending_results.size() != 0)
                && $urandom_range(99) >= sender_idle_pct()) begin
               cur = cmd_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {cur.prio, cur.key};
               req_tuser <= cur.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result transfer against the oldest prediction.
   always @(posedge clock) begin : monitor_proc
      rsp_type got;
      rsp_type want;
      bit      bad;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.out_key = rsp_tdata[31:0];
            got.out_priority = rsp_tdata[63:32];
            got.fill_level = rsp_tdata[74:64];
            got.status = status_type'(rsp_tuser);
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result with no command outstanding: key %h prio %h st %0d fill %0d",
                           $realtime, got.out_key, got.out_priority, got.status, got.fill_level);
            end else begin
               want = pending_results.pop_front();
               bad = (got.out_key !== want.out_key) || (got.out_priority !== want.out_priority)
                     || (got.status !== want.status) || (got.fill_level !== want.fill_level)
                     || (rsp_tdata[79:75] !== 5'd0);
               if (bad) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: mismatch: exp key %h prio %h st %0d fill %0d pad 0, got key %h prio %h st %0d fill %0d pad %h",
                              $realtime, want.out_key, want.out_priority, want.status,
                              want.fill_level, got.out_key, got.out_priority, got.status,
                              got.fill_level, rsp_tdata[79:75]);
               end
            end
         end
         // Hold off the result side for a long stretch once per 250 commands.
         if (sent_count / 250 != hold_mark) begin
            hold_mark = sent_count / 250;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_idle_pct());
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin : stimulus_proc
      int unsigned n;
      int unsigned push_pct;
      // Directed part: empty pop, field extremes, equal priorities, drain.
      add_cmd(CMD_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      add_cmd(CMD_PUSH, 32'h0000_0000, 32'h0000_0000, 1'b0);
      add_cmd(CMD_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      add_cmd(CMD_PUSH, 32'h1234_5678, 32'h8000_0000, 1'b0);
      add_cmd(CMD_PUSH, 32'h8765_4321, 32'h8000_0000, 1'b0);
      add_cmd(CMD_PUSH, 32'h1111_1111, 32'h0000_0007, 1'b0);
      add_cmd(CMD_PUSH, 32'h2222_2222, 32'h0000_0007, 1'b0);
      add_cmd(CMD_PUSH, 32'h3333_3333, 32'h0000_0007, 1'b0);
      add_cmd(CMD_PUSH, 32'hA5A5_A5A5, 32'hFFFF_FFFF, 1'b0);
      for (int i = 0; i < 9; i++)
         add_cmd(CMD_POP, $urandom, $urandom, 1'b0);

      // Mixed random traffic in segments of varying push bias.
      for (int s = 0; s < MIXED_CMDS / 150; s++) begin
         case (s % 3)
            0:       push_pct = 80;
            1:       push_pct = 50;
            default: push_pct = 25;
         endcase
         for (int i = 0; i < 150; i++)
            add_cmd(($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP,
                    $urandom, pick_priority(), (i == 0));
      end

      // Push a burst to deepen the heap, churn, then drain past empty.
      for (int i = 0; i < BURST_PUSHES; i++)
         add_cmd(CMD_PUSH, $urandom, pick_priority(), (i == 0));
      for (int i = 0; i < 20; i++)
         add_cmd($urandom_range(1) ? CMD_PUSH : CMD_POP, $urandom, pick_priority(), 1'b0);
      n = planned_fill + 2;
      for (int i = 0; i < n; i++)
         add_cmd(CMD_POP, $urandom, $urandom, 1'b0);
      total_cmds = cmd_backlog.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      do
         @(posedge clock);
      while (cmd_backlog.size() != 0 || req_tvalid || pending_results.size() != 0);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Run limit, many times the slowest expected run.
   initial begin
      #10ms;
      $display("simulation failed");
      $finish;
   end

endmodule
